>>> rtl/assert_macros.svh
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ALC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/alc_pkg.sv
// constants and types of the boundary-tag allocator
package alc_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int STORE_WORDS = HEAP_BYTES / 4;
  localparam int WORD_AW     = $clog2(STORE_WORDS);
  localparam int ADDR_W      = WORD_AW + 4;
  localparam int TAG_W       = 17;
  localparam int REQ_W       = 20;
  localparam int ASZ_W       = 21;
  localparam int OFS_W       = 16;
  localparam int FIRST_BLOCK = 8;
  localparam int MIN_BLOCK   = 16;
  localparam int CHUNK_RESET = 4096;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ZERO    = 2'd1;
  localparam logic [1:0] STAT_NOMEM   = 2'd2;
  localparam logic [1:0] STAT_NOINIT  = 2'd3;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  wdata;
  } tag_req_t;

endpackage

>>> rtl/alc_chan_if.sv
// request and result channels of the allocator
interface alc_in_if;
  import alc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [REQ_W-1:0]  request_bytes;
  logic [OFS_W-1:0]  free_address;
  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface alc_out_if;
  import alc_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] block_address;
  logic [1:0]       status;
  modport source (output valid, block_address, status, input ready);
  modport sink (input valid, block_address, status, output ready);
endinterface

>>> rtl/alc_ram.sv
// generic single-write, registered-read ram
module alc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/alc_tags.sv
// tag store access with range check, out-of-range reads give zero
module alc_tags (
  input  logic                             clk,
  input  logic                             rst_n,
  input  alc_pkg::tag_req_t                req,
  output logic [alc_pkg::TAG_W-1:0]        rdata
);
  import alc_pkg::*;

  logic             in_rng;
  logic             oob_r;
  logic [TAG_W-1:0] ram_q;

  assign in_rng = req.addr < ADDR_W'(HEAP_BYTES);

  alc_ram #(.WIDTH(TAG_W), .DEPTH(STORE_WORDS)) u_ram (
    .clk   (clk),
    .we    (req.wr && in_rng),
    .waddr (req.addr[WORD_AW+1:2]),
    .wdata (req.wdata),
    .re    (req.rd && in_rng),
    .raddr (req.addr[WORD_AW+1:2]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oob_r <= 1'b0;
    end else if (req.rd) begin
      oob_r <= !in_rng;
    end
  end

  assign rdata = oob_r ? '0 : ram_q;
endmodule

>>> rtl/implicit_list_next_fit_allocator.sv
// top level: boundary-tag heap manager with next-fit search
//
// in_ch carries one command word per handshake: mode (init, allocate,
// free), request_bytes and free_address. out_ch returns one result word per
// command: block_address and status. cfg_we/cfg_wdata write the minimum
// growth chunk in bytes; write it only while the block is idle.
// One command is worked on at a time. The sequencer makes every tag store
// access through one port with a registered read, one access per cycle.
// Init writes the prologue and epilogue tags, then grows the heap by one chunk;
// free clears the allocated bit in both tags and coalesces (nothing when the
// header is empty); allocate walks the list, then places and splits, and
// grows the heap first when no block fits. A command with no tag work raises
// out_ch.valid at the accepting edge itself.
// The result sits in an output register; in_ch.ready stays low while it is
// not taken, so a stalled receiver holds the block.
// Reset clears the heap state to uninitialized and sets the chunk to 4096;
// tag store contents are undefined until an init lays the heap down.
module implicit_list_next_fit_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  alc_in_if.sink                    in_ch,
  alc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [alc_pkg::TAG_W-1:0] cfg_wdata
);
  import alc_pkg::*;
  `include "assert_macros.svh"

  localparam logic [5:0] ST_IDLE = 6'd0,  ST_I0 = 6'd1,   ST_I1 = 6'd2,   ST_I2 = 6'd3;
  localparam logic [5:0] ST_I3   = 6'd4,  ST_G0 = 6'd5,   ST_G1 = 6'd6,   ST_G2 = 6'd7;
  localparam logic [5:0] ST_G3   = 6'd8,  ST_M0 = 6'd9,   ST_M1 = 6'd10,  ST_M2 = 6'd11;
  localparam logic [5:0] ST_M3   = 6'd12, ST_M4 = 6'd13,  ST_M5 = 6'd14,  ST_M6 = 6'd15;
  localparam logic [5:0] ST_M7   = 6'd16, ST_M8 = 6'd17,  ST_PA1 = 6'd18, ST_PA2 = 6'd19;
  localparam logic [5:0] ST_NA1  = 6'd20, ST_PH = 6'd21,  ST_MRET = 6'd22, ST_SCHK = 6'd23;
  localparam logic [5:0] ST_SEVAL = 6'd24, ST_C0 = 6'd25, ST_C1 = 6'd26,  ST_C2 = 6'd27;
  localparam logic [5:0] ST_C3   = 6'd28, ST_C4 = 6'd29,  ST_C5 = 6'd30,  ST_F0 = 6'd31;
  localparam logic [5:0] ST_F1   = 6'd32, ST_F2 = 6'd33;

  localparam logic [1:0] CTX_INIT = 2'd0, CTX_ALLOC = 2'd1, CTX_FREE = 2'd2;

  logic [5:0]        state_r, state_nxt;
  logic [1:0]        ctx_r, ctx_nxt;
  logic              pass_r, pass_nxt;
  logic [ADDR_W-1:0] bp_r, bp_nxt;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic [ADDR_W-1:0] nxt_r, nxt_nxt;
  logic [TAG_W-1:0]  size_r, size_nxt;
  logic [TAG_W-1:0]  nsize_r, nsize_nxt;
  logic [TAG_W-1:0]  pf_r, pf_nxt;
  logic [TAG_W-1:0]  acc_r, acc_nxt;
  logic              pa_r, pa_nxt;
  logic              na_r, na_nxt;
  logic [ASZ_W-1:0]  asize_r, asize_nxt;
  logic [ASZ_W-1:0]  gsize_r, gsize_nxt;
  logic [OFS_W-1:0]  rover_r, rover_nxt;
  logic [TAG_W-1:0]  heap_end_r, heap_end_nxt;
  logic              init_r, init_nxt;
  logic [TAG_W-1:0]  chunk_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OFS_W-1:0]  out_addr_r, out_addr_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  tag_req_t          treq;
  logic [TAG_W-1:0]  rdata;
  logic [TAG_W-1:0]  rd_size;
  logic              accept;
  logic [ADDR_W-1:0] chunk_v;
  logic [ASZ_W-1:0]  gmax;

  alc_tags u_tags (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .rdata (rdata)
  );

  assign rd_size      = {rdata[TAG_W-1:3], 3'b000};
  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.status        = out_status_r;

  // rounded growth chunk, never below the minimum block
  always_comb begin
    logic [ADDR_W-1:0] cw;
    cw = ADDR_W'({chunk_r[TAG_W-1:2], 2'b00}) + ADDR_W'(7);
    chunk_v = {cw[ADDR_W-1:3], 3'b000};
    if (chunk_v < ADDR_W'(MIN_BLOCK)) begin
      chunk_v = ADDR_W'(MIN_BLOCK);
    end
    gmax = (asize_r > ASZ_W'(chunk_v)) ? asize_r : ASZ_W'(chunk_v);
  end

  always_comb begin
    logic [ASZ_W-1:0]  t;
    logic [OFS_W-1:0]  fa;
    logic              lim_ok;
    logic              fin;
    logic [OFS_W-1:0]  fin_addr;
    logic [1:0]        fin_stat;
    state_nxt = state_r;  ctx_nxt = ctx_r;  pass_nxt = pass_r;
    bp_nxt = bp_r;  prev_nxt = prev_r;  nxt_nxt = nxt_r;
    size_nxt = size_r;  nsize_nxt = nsize_r;  pf_nxt = pf_r;  acc_nxt = acc_r;
    pa_nxt = pa_r;  na_nxt = na_r;  asize_nxt = asize_r;  gsize_nxt = gsize_r;
    rover_nxt = rover_r;  heap_end_nxt = heap_end_r;  init_nxt = init_r;
    treq = '0;
    fin = 1'b0;  fin_addr = '0;  fin_stat = STAT_OK;
    t = '0;  fa = '0;  lim_ok = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t  = ASZ_W'(in_ch.request_bytes) + ASZ_W'(15);
          fa = {in_ch.free_address[OFS_W-1:3], 3'b000};
          unique case (in_ch.mode)
            MODE_INIT: begin
              ctx_nxt   = CTX_INIT;
              state_nxt = ST_I0;
            end
            MODE_ALLOC: begin
              if (!init_r) begin
                fin = 1'b1;  fin_stat = STAT_NOINIT;
              end else if (in_ch.request_bytes == '0) begin
                fin = 1'b1;  fin_stat = STAT_ZERO;
              end else begin
                asize_nxt = (in_ch.request_bytes <= REQ_W'(8)) ? ASZ_W'(MIN_BLOCK)
                                                              : {t[ASZ_W-1:3], 3'b000};
                ctx_nxt   = CTX_ALLOC;
                bp_nxt    = ADDR_W'(rover_r);
                pass_nxt  = 1'b0;
                state_nxt = ST_SCHK;
              end
            end
            MODE_FREE: begin
              if (!init_r) begin
                fin = 1'b1;  fin_stat = STAT_NOINIT;
              end else if (fa >= OFS_W'(MIN_BLOCK) && TAG_W'(fa) < heap_end_r) begin
                ctx_nxt   = CTX_FREE;
                bp_nxt    = ADDR_W'(fa);
                state_nxt = ST_F0;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      // heap prologue and epilogue
      ST_I0: begin
        treq.wr = 1'b1;  treq.addr = ADDR_W'(0);  treq.wdata = '0;
        state_nxt = ST_I1;
      end
      ST_I1: begin
        treq.wr = 1'b1;  treq.addr = ADDR_W'(4);  treq.wdata = TAG_W'(9);
        state_nxt = ST_I2;
      end
      ST_I2: begin
        treq.wr = 1'b1;  treq.addr = ADDR_W'(8);  treq.wdata = TAG_W'(9);
        state_nxt = ST_I3;
      end
      ST_I3: begin
        treq.wr = 1'b1;  treq.addr = ADDR_W'(12);  treq.wdata = TAG_W'(1);
        init_nxt     = 1'b0;
        heap_end_nxt = TAG_W'(16);
        rover_nxt    = OFS_W'(FIRST_BLOCK);
        gsize_nxt    = ASZ_W'(chunk_v);
        state_nxt    = ST_G0;
      end
      // heap growth
      ST_G0: begin
        if (gsize_r > ASZ_W'(HEAP_BYTES) ||
            ASZ_W'(heap_end_r) + gsize_r > ASZ_W'(HEAP_BYTES)) begin
          fin = 1'b1;  fin_stat = STAT_NOMEM;
        end else begin
          bp_nxt       = ADDR_W'(heap_end_r);
          size_nxt     = TAG_W'(gsize_r);
          heap_end_nxt = TAG_W'(ASZ_W'(heap_end_r) + gsize_r);
          state_nxt    = ST_G1;
        end
      end
      ST_G1: begin
        treq.wr = 1'b1;  treq.addr = bp_r - ADDR_W'(4);  treq.wdata = size_r;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(8);
        treq.wdata = size_r;
        state_nxt = ST_G3;
      end
      ST_G3: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(4);
        treq.wdata = TAG_W'(1);
        state_nxt = ST_M0;
      end
      // coalescing
      ST_M0: begin
        treq.rd = 1'b1;  treq.addr = bp_r - ADDR_W'(8);
        state_nxt = ST_M1;
      end
      ST_M1: begin
        pa_nxt = rdata[0];  pf_nxt = rd_size;
        treq.rd = 1'b1;  treq.addr = bp_r - ADDR_W'(4);
        state_nxt = ST_M2;
      end
      ST_M2: begin
        size_nxt = rd_size;
        nxt_nxt  = bp_r + ADDR_W'(rd_size);
        prev_nxt = bp_r - ADDR_W'(pf_r);
        treq.rd = 1'b1;  treq.addr = bp_r + ADDR_W'(rd_size) - ADDR_W'(4);
        state_nxt = ST_M3;
      end
      ST_M3: begin
        na_nxt = rdata[0];  nsize_nxt = rd_size;
        if (pa_r && rdata[0]) begin
          state_nxt = ST_MRET;
        end else if (pa_r) begin
          acc_nxt   = size_r + rd_size;
          state_nxt = ST_PA1;
        end else begin
          state_nxt = ST_M4;
        end
      end
      ST_M4: begin
        treq.rd = 1'b1;  treq.addr = prev_r - ADDR_W'(4);
        state_nxt = ST_M5;
      end
      ST_M5: begin
        acc_nxt   = size_r + rd_size;
        state_nxt = na_r ? ST_NA1 : ST_M6;
      end
      ST_M6: begin
        treq.rd = 1'b1;  treq.addr = nxt_r + ADDR_W'(nsize_r) - ADDR_W'(8);
        state_nxt = ST_M7;
      end
      ST_M7: begin
        acc_nxt   = acc_r + rd_size;
        state_nxt = ST_M8;
      end
      ST_M8: begin
        treq.wr = 1'b1;  treq.addr = nxt_r + ADDR_W'(nsize_r) - ADDR_W'(8);
        treq.wdata = acc_r;
        state_nxt = ST_PH;
      end
      ST_PA1: begin
        treq.wr = 1'b1;  treq.addr = bp_r - ADDR_W'(4);  treq.wdata = acc_r;
        state_nxt = ST_PA2;
      end
      ST_PA2: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(acc_r) - ADDR_W'(8);
        treq.wdata = acc_r;
        rover_nxt = OFS_W'(bp_r);
        state_nxt = ST_MRET;
      end
      ST_NA1: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(8);
        treq.wdata = acc_r;
        state_nxt = ST_PH;
      end
      ST_PH: begin
        treq.wr = 1'b1;  treq.addr = prev_r - ADDR_W'(4);  treq.wdata = acc_r;
        bp_nxt    = prev_r;
        rover_nxt = OFS_W'(prev_r);
        state_nxt = ST_MRET;
      end
      ST_MRET: begin
        unique case (ctx_r)
          CTX_INIT: begin
            rover_nxt = OFS_W'(FIRST_BLOCK);
            init_nxt  = 1'b1;
            fin       = 1'b1;
          end
          CTX_ALLOC: begin
            state_nxt = ST_C0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      // list walk: next fit from the rover, then first fit up to it
      ST_SCHK: begin
        lim_ok = pass_r ? (bp_r < ADDR_W'(rover_r)) : (bp_r < ADDR_W'(HEAP_BYTES));
        if (lim_ok) begin
          treq.rd = 1'b1;  treq.addr = bp_r - ADDR_W'(4);
          state_nxt = ST_SEVAL;
        end else if (!pass_r) begin
          pass_nxt = 1'b1;  bp_nxt = ADDR_W'(FIRST_BLOCK);
        end else begin
          gsize_nxt = gmax;  state_nxt = ST_G0;
        end
      end
      ST_SEVAL: begin
        if (rd_size == '0) begin
          if (!pass_r) begin
            pass_nxt = 1'b1;  bp_nxt = ADDR_W'(FIRST_BLOCK);  state_nxt = ST_SCHK;
          end else begin
            gsize_nxt = gmax;  state_nxt = ST_G0;
          end
        end else if (!rdata[0] && asize_r <= ASZ_W'(rd_size)) begin
          if (!pass_r) begin
            rover_nxt = OFS_W'(bp_r);
          end
          state_nxt = ST_C0;
        end else begin
          bp_nxt    = bp_r + ADDR_W'(rd_size);
          state_nxt = ST_SCHK;
        end
      end
      // placement and split
      ST_C0: begin
        treq.rd = 1'b1;  treq.addr = bp_r - ADDR_W'(4);
        state_nxt = ST_C1;
      end
      ST_C1: begin
        size_nxt = rd_size;
        treq.wr = 1'b1;  treq.addr = bp_r - ADDR_W'(4);
        if (ASZ_W'(rd_size) >= asize_r + ASZ_W'(MIN_BLOCK)) begin
          treq.wdata = TAG_W'(asize_r) | TAG_W'(1);
          state_nxt  = ST_C2;
        end else begin
          treq.wdata = rd_size | TAG_W'(1);
          state_nxt  = ST_C5;
        end
      end
      ST_C2: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(asize_r) - ADDR_W'(8);
        treq.wdata = TAG_W'(asize_r) | TAG_W'(1);
        state_nxt = ST_C3;
      end
      ST_C3: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(asize_r) - ADDR_W'(4);
        treq.wdata = size_r - TAG_W'(asize_r);
        state_nxt = ST_C4;
      end
      ST_C4: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(8);
        treq.wdata = size_r - TAG_W'(asize_r);
        fin = 1'b1;  fin_addr = OFS_W'(bp_r);
      end
      ST_C5: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(8);
        treq.wdata = size_r | TAG_W'(1);
        fin = 1'b1;  fin_addr = OFS_W'(bp_r);
      end
      // release
      ST_F0: begin
        treq.rd = 1'b1;  treq.addr = bp_r - ADDR_W'(4);
        state_nxt = ST_F1;
      end
      ST_F1: begin
        if (rd_size == '0) begin
          fin = 1'b1;
        end else begin
          size_nxt = rd_size;
          treq.wr = 1'b1;  treq.addr = bp_r - ADDR_W'(4);  treq.wdata = rd_size;
          state_nxt = ST_F2;
        end
      end
      ST_F2: begin
        treq.wr = 1'b1;  treq.addr = bp_r + ADDR_W'(size_r) - ADDR_W'(8);
        treq.wdata = size_r;
        state_nxt = ST_M0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
    end
    out_valid_nxt  = fin || (out_valid_r && !out_ch.ready);
    out_addr_nxt   = fin ? fin_addr : out_addr_r;
    out_status_nxt = fin ? fin_stat : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rover_r     <= '0;
      heap_end_r  <= '0;
      init_r      <= 1'b0;
      chunk_r     <= TAG_W'(CHUNK_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      heap_end_r  <= heap_end_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        chunk_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_r        <= ctx_nxt;
    pass_r       <= pass_nxt;
    bp_r         <= bp_nxt;
    prev_r       <= prev_nxt;
    nxt_r        <= nxt_nxt;
    size_r       <= size_nxt;
    nsize_r      <= nsize_nxt;
    pf_r         <= pf_nxt;
    acc_r        <= acc_nxt;
    pa_r         <= pa_nxt;
    na_r         <= na_nxt;
    asize_r      <= asize_nxt;
    gsize_r      <= gsize_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  `ALC_ASSERT_NOW(a_heap_end_aligned, clk, rst_n, 1'b1, heap_end_r[2:0] == 3'b000)
  `ALC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept && in_ch.mode == MODE_INIT, state_r != ST_IDLE)
  `ALC_ASSERT_NOW(a_no_write_idle, clk, rst_n, state_r == ST_IDLE, !treq.wr && !treq.rd)
  `ALC_ASSERT_NOW(a_out_only_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
endmodule

>>> tb/sv/tb_implicit_list_next_fit_allocator.sv
// testbench for the next-fit boundary-tag allocator: directed and random words against a predictor
`timescale 1ns / 1ps

module tb_implicit_list_next_fit_allocator;
  import alc_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [OFS_W-1:0] block_address;
    logic [1:0]       status;
  } alloc_result_t;

  class heap_scoreboard;
    bit [TAG_W-1:0] tags [STORE_WORDS];
    int unsigned heap_end;
    int unsigned rover;
    int unsigned chunk_cfg;
    bit          heap_live;
    alloc_result_t pending[$];
    int          fails;

    function new();
      chunk_cfg = CHUNK_RESET;
    endfunction

    function int unsigned rd(int unsigned a);
      int unsigned w;
      w = a >> 2;
      return (w < STORE_WORDS) ? int'(tags[w]) : 0;
    endfunction

    function void wr(int unsigned a, int unsigned v);
      int unsigned w;
      w = a >> 2;
      if (w < STORE_WORDS) tags[w] = v[TAG_W-1:0];
    endfunction

    function int unsigned hsz(int unsigned bp);
      return rd(bp - 4) & ~32'd7;
    endfunction

    function int unsigned hal(int unsigned bp);
      return rd(bp - 4) & 32'd1;
    endfunction

    function int unsigned prv(int unsigned bp);
      return bp - (rd(bp - 8) & ~32'd7);
    endfunction

    function void set_tags(int unsigned bp, int unsigned sz, int unsigned al);
      wr(bp - 4, sz | al);
      wr(bp + sz - 8, sz | al);
    endfunction

    function int unsigned coalesce(int unsigned bp);
      int unsigned pa, na, sz, nb;
      pa = rd(bp - 8) & 32'd1;
      na = hal(bp + hsz(bp));
      sz = hsz(bp);
      if (pa != 0 && na != 0) return bp;
      if (pa != 0) begin
        sz += hsz(bp + hsz(bp));
        set_tags(bp, sz, 0);
      end else if (na != 0) begin
        sz += hsz(prv(bp));
        wr(bp + hsz(bp) - 8, sz);
        bp = prv(bp);
        wr(bp - 4, sz);
      end else begin
        nb = bp + hsz(bp);
        sz += hsz(prv(bp)) + (rd(nb + hsz(nb) - 8) & ~32'd7);
        wr(nb + hsz(nb) - 8, sz);
        bp = prv(bp);
        wr(bp - 4, sz);
      end
      rover = bp;
      return bp;
    endfunction

    function int unsigned grow_heap(int unsigned sz);
      int unsigned bp;
      bp = heap_end;
      if (sz > HEAP_BYTES || bp > HEAP_BYTES - sz) return 0;
      heap_end = bp + sz;
      set_tags(bp, sz, 0);
      wr(bp + sz - 4, 1);
      return coalesce(bp);
    endfunction

    function int unsigned chunk_bytes();
      int unsigned c;
      c = ((chunk_cfg & ~32'd3) + 7) & ~32'd7;
      return (c < MIN_BLOCK) ? MIN_BLOCK : c;
    endfunction

    function int unsigned seek_block(int unsigned asz);
      int unsigned bp;
      bp = rover;
      while (bp < HEAP_BYTES && hsz(bp) > 0) begin
        if (hal(bp) == 0 && asz <= hsz(bp)) begin
          rover = bp;
          return bp;
        end
        bp = bp + hsz(bp);
      end
      bp = FIRST_BLOCK;
      while (bp < rover && hsz(bp) > 0) begin
        if (hal(bp) == 0 && asz <= hsz(bp)) return bp;
        bp = bp + hsz(bp);
      end
      return 0;
    endfunction

    function void place(int unsigned bp, int unsigned asz);
      int unsigned csz;
      csz = hsz(bp);
      if (csz >= asz + MIN_BLOCK) begin
        set_tags(bp, asz, 1);
        set_tags(bp + asz, csz - asz, 0);
      end else begin
        set_tags(bp, csz, 1);
      end
    endfunction

    function alloc_result_t note_word(logic [1:0] mode, logic [REQ_W-1:0] req,
                                      logic [OFS_W-1:0] faddr_in);
      alloc_result_t r;
      int unsigned asz, bp, c, faddr;
      r.block_address = '0;
      r.status = STAT_OK;
      faddr = 32'(faddr_in & ~16'd7);
      if (mode == MODE_INIT) begin
        heap_live = 0;
        heap_end = 16;
        wr(0, 0);
        wr(4, 9);
        wr(8, 9);
        wr(12, 1);
        rover = FIRST_BLOCK;
        if (grow_heap(chunk_bytes()) == 0) begin
          r.status = STAT_NOMEM;
        end else begin
          rover = FIRST_BLOCK;
          heap_live = 1;
        end
      end else if (mode == MODE_ALLOC) begin
        if (!heap_live) begin
          r.status = STAT_NOINIT;
        end else if (req == 0) begin
          r.status = STAT_ZERO;
        end else begin
          asz = (req <= 8) ? MIN_BLOCK : 8 * ((int'(req) + 15) / 8);
          bp = seek_block(asz);
          if (bp == 0) begin
            c = chunk_bytes();
            bp = grow_heap(asz > c ? asz : c);
          end
          if (bp == 0) begin
            r.status = STAT_NOMEM;
          end else begin
            place(bp, asz);
            r.block_address = bp[OFS_W-1:0];
          end
        end
      end else if (mode == MODE_FREE) begin
        if (!heap_live) begin
          r.status = STAT_NOINIT;
        end else if (faddr >= MIN_BLOCK && faddr < heap_end && hsz(faddr) > 0) begin
          set_tags(faddr, hsz(faddr), 0);
          void'(coalesce(faddr));
        end
      end
      pending.push_back(r);
      return r;
    endfunction

    function void check_word(logic [OFS_W-1:0] addr, logic [1:0] status);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual addr %0d status %0d",
                 $time, addr, status);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (addr !== e.block_address) begin
        $display("%0t: block_address mismatch, expected %0d actual %0d",
                 $time, e.block_address, addr);
        fails++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, status);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TAG_W-1:0] cfg_wdata;
  alc_in_if  in_ch();
  alc_out_if out_ch();

  heap_scoreboard sb;
  int unsigned live_blocks[$];
  bit stalls_on;
  int stall_left = 0;
  int cycles = 0;

  implicit_list_next_fit_allocator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_word(out_ch.block_address, out_ch.status);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_word(logic [1:0] mode, logic [REQ_W-1:0] req, logic [OFS_W-1:0] faddr);
    alloc_result_t r;
    int idx;
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.request_bytes = req;
    in_ch.free_address = faddr;
    do @(posedge clk); while (!in_ch.ready);
    r = sb.note_word(mode, req, faddr);
    if (mode == MODE_INIT) live_blocks.delete();
    if (mode == MODE_ALLOC && r.status == STAT_OK) live_blocks.push_back(32'(r.block_address));
    if (mode == MODE_FREE) begin
      for (idx = 0; idx < live_blocks.size(); idx++)
        if (live_blocks[idx] == (faddr & ~16'd7)) begin
          live_blocks.delete(idx);
          break;
        end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_chunk(int unsigned v);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v[TAG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.chunk_cfg = v & 32'h1FFFF;
  endtask

  task automatic random_word();
    int unsigned pick, a;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      a = $urandom_range(0, 99);
      if (a < 4) req = '0;
      else if (a < 78) req = REQ_W'($urandom_range(1, 256));
      else if (a < 95) req = REQ_W'($urandom_range(257, 4000));
      else req = REQ_W'($urandom);
      send_word(MODE_ALLOC, req, OFS_W'($urandom));
    end else if (pick < 92) begin
      a = $urandom_range(0, 9);
      if (a < 8 && live_blocks.size() > 0)
        send_word(MODE_FREE, REQ_W'($urandom),
                  OFS_W'(live_blocks[$urandom_range(0, live_blocks.size() - 1)] |
                         $urandom_range(0, 7)));
      else if (a == 8 || sb.heap_end > 65535)
        send_word(MODE_FREE, REQ_W'($urandom), OFS_W'($urandom_range(0, 15)));
      else
        send_word(MODE_FREE, REQ_W'($urandom), OFS_W'($urandom_range(sb.heap_end, 65535)));
    end else if (pick < 96) begin
      send_word(MODE_INIT, REQ_W'($urandom), OFS_W'($urandom));
    end else begin
      send_word(2'd3, REQ_W'($urandom), OFS_W'($urandom));
    end
  endtask

  initial begin
    int unsigned chunks[8];
    int p, k;
    chunks = '{16, 65536, 131071, 5, 200, 1024, 32768, 12345};
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_INIT;
    in_ch.request_bytes = '0;
    in_ch.free_address = '0;
    stalls_on = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // not initialised, unused mode, then a fresh heap at the reset chunk
    send_word(MODE_ALLOC, 20'd5, '0);
    send_word(MODE_FREE, '0, 16'd24);
    send_word(2'd3, 20'hFFFFF, 16'hFFFF);
    send_word(MODE_INIT, '0, '0);
    send_word(MODE_ALLOC, 20'd0, '0);
    send_word(MODE_ALLOC, 20'd1, '0);
    send_word(MODE_ALLOC, 20'd8, '0);
    send_word(MODE_ALLOC, 20'd9, '0);
    send_word(MODE_ALLOC, 20'hFFFFF, '0);
    send_word(MODE_ALLOC, 20'd3000, '0);
    send_word(MODE_ALLOC, 20'd60000, '0);
    send_word(MODE_FREE, '0, 16'd5);
    send_word(MODE_FREE, '0, 16'hFFFF);
    send_word(MODE_FREE, '0, OFS_W'(live_blocks[1] | 32'd7));
    send_word(MODE_FREE, '0, OFS_W'(live_blocks[0]));
    send_word(MODE_FREE, '0, OFS_W'(live_blocks[0]));
    send_word(MODE_ALLOC, 20'd24, '0);
    send_word(MODE_INIT, 20'hFFFFF, 16'hFFFF);
    send_word(MODE_ALLOC, 20'd40000, '0);
    send_word(MODE_ALLOC, 20'd40000, '0);

    for (p = 0; p < 8; p++) begin
      write_chunk(chunks[p]);
      if (p == 7) stalls_on = 1'b0;
      send_word(MODE_INIT, REQ_W'($urandom), OFS_W'($urandom));
      for (k = 0; k < 53; k++) random_word();
    end

    wait_idle();
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> implicit_list_next_fit_allocator.f
+incdir+rtl
rtl/alc_pkg.sv
rtl/alc_chan_if.sv
rtl/alc_ram.sv
rtl/alc_tags.sv
rtl/implicit_list_next_fit_allocator.sv
tb/sv/tb_implicit_list_next_fit_allocator.sv
